### hw/rtl/lss_pkg.sv
// Shared types and constants for the LIFO stack with scan.
package lss_pkg;

    localparam int DEPTH   = 64;
    localparam int ADDR_W  = $clog2(DEPTH);
    localparam int OCC_W   = $clog2(DEPTH + 1);
    localparam int DATA_W  = 32;
    localparam int FIELD_W = 7;
    localparam int OUT_W   = 152;

    typedef enum logic [1:0] {
        KIND_PUSH = 2'd0,
        KIND_POP  = 2'd1,
        KIND_SCAN = 2'd2
    } kind_t;

    typedef struct packed {
        logic [4:0]              pad;
        logic                    push_dropped;
        logic                    is_full;
        logic                    is_empty;
        logic [FIELD_W-1:0]      stack_size;
        logic                    extremes_valid;
        logic signed [DATA_W-1:0] min_value;
        logic signed [DATA_W-1:0] max_value;
        logic                    found;
        logic [FIELD_W-1:0]      match_count;
        logic signed [DATA_W-1:0] top_value;
        logic signed [DATA_W-1:0] popped_value;
    } result_t;

endpackage

### hw/rtl/lifo_stack_with_scan.sv
// LIFO stack of signed words with a sequenced scan for matches and extremes.
//
//  channel | direction | tdata (low bit up)      | tuser
//  s_      | in        | value                   | kind
//  m_      | out       | result word (see port)  | -
//
// An accepted word moves the sequencer straight to the finishing state on a push,
// on a pop of at most one entry and on a scan of an empty stack; a longer pop passes
// a read and a take state, and a scan a read and a compare state per entry: the single
// read port of the entry store and the one compare unit handle one entry at a time.
// Reset clears the occupancy and control state; the entry store is not cleared.
// A new word is taken only when the sequencer is idle; a finished result waits
// in the output register while m_tready is low, and the block stalls only
// if the next result is ready before that register has been emptied.
module lifo_stack_with_scan
    import lss_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              s_tvalid,
    output logic              s_tready,
    input  logic [31:0]       s_tdata,   // value
    input  logic [1:0]        s_tuser,   // kind
    output logic              m_tvalid,
    input  logic              m_tready,
    // popped_value, top_value, match_count, found, max_value, min_value,
    // extremes_valid, stack_size, is_empty, is_full, push_dropped, zero pad
    output logic [OUT_W-1:0]  m_tdata
);

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_POP_RD,
        ST_POP_TAKE,
        ST_SCAN_RD,
        ST_SCAN_CMP,
        ST_FINISH
    } state_t;

    state_t                   state_reg;
    logic [OCC_W-1:0]         occ_reg;
    logic [ADDR_W-1:0]        addr_reg;
    logic signed [DATA_W-1:0] top_reg;
    logic signed [DATA_W-1:0] key_reg;
    logic signed [DATA_W-1:0] popped_reg;
    logic signed [DATA_W-1:0] max_reg;
    logic signed [DATA_W-1:0] min_reg;
    logic [OCC_W-1:0]         cnt_reg;
    logic                     ext_valid_reg;
    logic                     dropped_reg;
    logic                     m_tvalid_reg;
    result_t                  out_reg;

    logic [DATA_W-1:0]        mem [DEPTH];
    logic signed [DATA_W-1:0] rd_data_reg;

    logic                     accept;
    kind_t                    in_kind;
    logic                     not_empty;
    logic                     scan_start;
    logic                     wr_en;
    logic                     full;
    logic [ADDR_W-1:0]        last_addr;
    logic                     cmp_eq;
    logic                     cmp_gt;
    logic                     cmp_lt;
    result_t                  res_next;

    assign s_tready   = (state_reg == ST_IDLE);
    assign accept     = s_tvalid && s_tready;
    assign in_kind    = kind_t'(s_tuser);
    assign not_empty  = (occ_reg != '0);
    assign scan_start = (in_kind == KIND_SCAN) && not_empty;
    assign full       = (occ_reg >= OCC_W'(DEPTH));
    assign wr_en      = accept && (in_kind == KIND_PUSH) && !full;
    assign last_addr  = ADDR_W'(occ_reg - OCC_W'(1));
    assign m_tvalid   = m_tvalid_reg;
    assign m_tdata    = out_reg;

    // The shared compare unit: one entry against the key and both extremes.
    assign cmp_eq = (rd_data_reg == key_reg);
    assign cmp_gt = (rd_data_reg > max_reg);
    assign cmp_lt = (rd_data_reg < min_reg);

    always_comb
    begin
        res_next                = '0;
        res_next.popped_value   = popped_reg;
        res_next.top_value      = top_reg;
        res_next.match_count    = FIELD_W'(cnt_reg);
        res_next.found          = (cnt_reg != '0);
        res_next.max_value      = max_reg;
        res_next.min_value      = min_reg;
        res_next.extremes_valid = ext_valid_reg;
        res_next.stack_size     = FIELD_W'(occ_reg);
        res_next.is_empty       = (occ_reg == '0);
        res_next.is_full        = full;
        res_next.push_dropped   = dropped_reg;
    end

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[occ_reg[ADDR_W-1:0]] <= s_tdata;
        end
        rd_data_reg <= mem[addr_reg];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            occ_reg       <= '0;
            top_reg       <= '0;
            m_tvalid_reg  <= 1'b0;
            addr_reg      <= '0;
            key_reg       <= '0;
            popped_reg    <= '0;
            max_reg       <= '0;
            min_reg       <= '0;
            cnt_reg       <= '0;
            ext_valid_reg <= 1'b0;
            dropped_reg   <= 1'b0;
            out_reg       <= '0;
        end
        else
        begin
            // In the finishing state the output register is handled below.
            if (m_tvalid_reg && m_tready && (state_reg != ST_FINISH))
            begin
                m_tvalid_reg <= 1'b0;
            end

            case (state_reg)
                ST_IDLE:
                begin
                    if (accept)
                    begin
                        key_reg       <= s_tdata;
                        cnt_reg       <= '0;
                        dropped_reg   <= (in_kind == KIND_PUSH) && full;
                        popped_reg    <= ((in_kind == KIND_POP) && not_empty) ? top_reg : '0;
                        // Both extremes of a scan start from the top entry.
                        max_reg       <= scan_start ? top_reg : '0;
                        min_reg       <= scan_start ? top_reg : '0;
                        ext_valid_reg <= scan_start;
                        case (in_kind)
                            KIND_PUSH:
                            begin
                                state_reg <= ST_FINISH;
                                if (!full)
                                begin
                                    top_reg <= s_tdata;
                                    occ_reg <= occ_reg + OCC_W'(1);
                                end
                            end
                            KIND_POP:
                            begin
                                if (not_empty)
                                begin
                                    occ_reg <= occ_reg - OCC_W'(1);
                                end
                                if (occ_reg > OCC_W'(1))
                                begin
                                    // The entry below the old top becomes the new top.
                                    addr_reg  <= ADDR_W'(occ_reg - OCC_W'(2));
                                    state_reg <= ST_POP_RD;
                                end
                                else
                                begin
                                    top_reg   <= '0;
                                    state_reg <= ST_FINISH;
                                end
                            end
                            KIND_SCAN:
                            begin
                                if (not_empty)
                                begin
                                    addr_reg  <= '0;
                                    state_reg <= ST_SCAN_RD;
                                end
                                else
                                begin
                                    state_reg <= ST_FINISH;
                                end
                            end
                            default:
                            begin
                                state_reg <= ST_FINISH;
                            end
                        endcase
                    end
                end
                ST_POP_RD:
                begin
                    state_reg <= ST_POP_TAKE;
                end
                ST_POP_TAKE:
                begin
                    top_reg   <= rd_data_reg;
                    state_reg <= ST_FINISH;
                end
                ST_SCAN_RD:
                begin
                    state_reg <= ST_SCAN_CMP;
                end
                ST_SCAN_CMP:
                begin
                    if (cmp_eq)
                    begin
                        cnt_reg <= cnt_reg + OCC_W'(1);
                    end
                    if (cmp_gt)
                    begin
                        max_reg <= rd_data_reg;
                    end
                    if (cmp_lt)
                    begin
                        min_reg <= rd_data_reg;
                    end
                    if (addr_reg == last_addr)
                    begin
                        state_reg <= ST_FINISH;
                    end
                    else
                    begin
                        addr_reg  <= addr_reg + ADDR_W'(1);
                        state_reg <= ST_SCAN_RD;
                    end
                end
                ST_FINISH:
                begin
                    if (!m_tvalid_reg || m_tready)
                    begin
                        out_reg      <= res_next;
                        m_tvalid_reg <= 1'b1;
                        state_reg    <= ST_IDLE;
                    end
                end
                default:
                begin
                    state_reg <= ST_IDLE;
                end
            endcase
        end
    end

    a_occ_bound: assert property (@(posedge clk) disable iff (!rst_n)
        occ_reg <= OCC_W'(DEPTH))
        else $error("occupancy beyond depth");

    a_push_grows: assert property (@(posedge clk) disable iff (!rst_n)
        (accept && (kind_t'(s_tuser) == KIND_PUSH) && !full)
        |=> (occ_reg == $past(occ_reg) + OCC_W'(1)))
        else $error("accepted push did not grow the stack");

    a_found_count: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid_reg |-> (out_reg.found == (out_reg.match_count != '0)))
        else $error("found flag disagrees with match count");

    a_extremes_order: assert property (@(posedge clk) disable iff (!rst_n)
        (m_tvalid_reg && out_reg.extremes_valid)
        |-> (out_reg.max_value >= out_reg.min_value))
        else $error("scan maximum below minimum");

    a_empty_flag: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid_reg |-> (out_reg.is_empty == (out_reg.stack_size == '0)))
        else $error("empty flag disagrees with size");

endmodule

### verif/tb_top.sv
`timescale 1ns / 100ps
// Self-checking testbench for the LIFO stack with scan: directed table, then random traffic.
module tb_top
    import lss_pkg::*;
();

    // The spare kind encoding, which the block treats as a no-op.
    localparam logic [1:0] KIND_NOP = 2'd3;

    localparam int RANDOM_ITEMS = 950;
    localparam int IDLE_PCT     = 22;
    localparam int HOLD_CYCLES  = 300;
    localparam int DRAIN_CYCLES = 200;
    localparam int STALL_LIMIT  = 2000;
    localparam int REPORT_MAX   = 10;
    localparam int DIR_N        = 22;

    typedef enum int {SEG_FILL, SEG_DRAIN, SEG_REPEAT, SEG_MIXED} seg_t;

    typedef struct packed {
        logic [1:0]  op;
        logic [31:0] val;
        logic        typed;
        result_t     exp;
    } dir_step_t;

    logic                clk;
    logic                rst_n    = 1'b0;
    logic                s_tvalid = 1'b0;
    logic                s_tready;
    logic [31:0]         s_tdata  = '0;
    logic [1:0]          s_tuser  = '0;
    logic                m_tvalid;
    logic                m_tready = 1'b0;
    logic [OUT_W-1:0]    m_tdata;

    logic signed [DATA_W-1:0] shadow_stack [DEPTH];
    int                       shadow_occ = 0;
    result_t                  pending_results [$];
    dir_step_t                dir_table [DIR_N];

    int mismatches    = 0;
    int quiet_cycles  = 0;
    int hold_requests = 0;
    int holds_served  = 0;
    int hold_left     = 0;
    bit calm          = 1'b0;

    lifo_stack_with_scan uut (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

    always
    begin
        clk = 1'b0;
        #6;
        clk = 1'b1;
        #6;
    end

    // Applies one operation to the shadow stack and returns the result word it should give.
    function automatic result_t predict_stack_op(logic [1:0] op, logic signed [DATA_W-1:0] val);
        result_t                  r;
        int                       hits;
        logic signed [DATA_W-1:0] hi;
        logic signed [DATA_W-1:0] lo;
        r    = '0;
        hits = 0;
        case (op)
            KIND_PUSH:
            begin
                if (shadow_occ >= DEPTH)
                    r.push_dropped = 1'b1;
                else
                begin
                    shadow_stack[shadow_occ] = val;
                    shadow_occ++;
                end
            end
            KIND_POP:
            begin
                if (shadow_occ > 0)
                begin
                    shadow_occ--;
                    r.popped_value = shadow_stack[shadow_occ];
                end
            end
            KIND_SCAN:
            begin
                if (shadow_occ > 0)
                begin
                    hi = shadow_stack[shadow_occ - 1];
                    lo = hi;
                    for (int i = 0; i < shadow_occ; i++)
                    begin
                        if (shadow_stack[i] == val)
                            hits++;
                        if (shadow_stack[i] > hi)
                            hi = shadow_stack[i];
                        if (shadow_stack[i] < lo)
                            lo = shadow_stack[i];
                    end
                    r.match_count    = hits[FIELD_W-1:0];
                    r.found          = (hits != 0);
                    r.max_value      = hi;
                    r.min_value      = lo;
                    r.extremes_valid = 1'b1;
                end
            end
            default:
            begin
            end
        endcase
        if (shadow_occ > 0)
            r.top_value = shadow_stack[shadow_occ - 1];
        r.stack_size = shadow_occ[FIELD_W-1:0];
        r.is_empty   = (shadow_occ == 0);
        r.is_full    = (shadow_occ >= DEPTH);
        return r;
    endfunction

    // Small values and the extremes turn up often, so that scans find matches.
    function automatic logic [31:0] pick_value();
        int r;
        r = $urandom_range(99);
        if (r < 30)
            return $urandom_range(3);
        if (r < 42)
        begin
            case ($urandom_range(3))
                0: return 32'h8000_0000;
                1: return 32'h7FFF_FFFF;
                2: return 32'hFFFF_FFFF;
                default: return 32'h0;
            endcase
        end
        return $urandom();
    endfunction

    function automatic bit field_bad(string name, logic [31:0] e, logic [31:0] g, bit report);
        if (g !== e)
        begin
            if (report)
                $display("mismatch in %s: expected %h, got %h", name, e, g);
            return 1'b1;
        end
        return 1'b0;
    endfunction

    task automatic send_word(input logic [1:0] op, input logic [31:0] val,
                             input bit typed, input result_t typed_exp);
        result_t predicted;
        while (!calm && $urandom_range(99) < IDLE_PCT)
        begin
            s_tvalid <= 1'b0;
            @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= val;
        s_tuser  <= op;
        @(posedge clk);
        while (!s_tready)
            @(posedge clk);
        predicted = predict_stack_op(op, val);
        pending_results.push_back(typed ? typed_exp : predicted);
    endtask

    // Result side: random back-pressure, plus a long hold-off whenever one is requested.
    always @(posedge clk)
    begin
        if (hold_left > 0)
        begin
            m_tready  <= 1'b0;
            hold_left <= hold_left - 1;
        end
        else if (holds_served != hold_requests)
        begin
            holds_served <= hold_requests;
            hold_left    <= HOLD_CYCLES;
            m_tready     <= 1'b0;
        end
        else
            m_tready <= calm || ($urandom_range(99) >= IDLE_PCT);
    end

    always @(posedge clk)
    begin
        result_t got;
        result_t exp;
        bit      report;
        bit      bad;
        if (rst_n && m_tvalid && m_tready)
        begin
            got    = m_tdata;
            report = (mismatches < REPORT_MAX);
            if (pending_results.size() == 0)
            begin
                if (report)
                    $display("unexpected result word %h", m_tdata);
                mismatches++;
            end
            else
            begin
                exp = pending_results.pop_front();
                bad = 1'b0;
                bad |= field_bad("popped_value", exp.popped_value, got.popped_value, report);
                bad |= field_bad("top_value", exp.top_value, got.top_value, report);
                bad |= field_bad("match_count", exp.match_count, got.match_count, report);
                bad |= field_bad("found", exp.found, got.found, report);
                bad |= field_bad("max_value", exp.max_value, got.max_value, report);
                bad |= field_bad("min_value", exp.min_value, got.min_value, report);
                bad |= field_bad("extremes_valid", exp.extremes_valid, got.extremes_valid,
                                 report);
                bad |= field_bad("stack_size", exp.stack_size, got.stack_size, report);
                bad |= field_bad("is_empty", exp.is_empty, got.is_empty, report);
                bad |= field_bad("is_full", exp.is_full, got.is_full, report);
                bad |= field_bad("push_dropped", exp.push_dropped, got.push_dropped, report);
                if (bad)
                    mismatches++;
            end
        end
    end

    // Ends the run if no word moves on either side for too long.
    always @(posedge clk)
    begin
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready))
            quiet_cycles <= 0;
        else if (quiet_cycles == STALL_LIMIT)
        begin
            $display("DONE: errors detected");
            $finish;
        end
        else
            quiet_cycles <= quiet_cycles + 1;
    end

    initial
    begin
        seg_t        mode;
        int          done_items;
        int          seg_idx;
        int          seg_len;
        int          pick;
        logic [1:0]  op;
        logic [31:0] val;
        logic [31:0] seg_val;

        // Expected columns: pad, push_dropped, is_full, is_empty, stack_size, extremes_valid,
        // min_value, max_value, found, match_count, top_value, popped_value.
        dir_table = '{
            '{KIND_POP,  32'h0000_0000, 1'b1, '{0, 0, 0, 1, 0, 0, 0, 0, 0, 0, 0, 0}},
            '{KIND_SCAN, 32'h0000_0005, 1'b1, '{0, 0, 0, 1, 0, 0, 0, 0, 0, 0, 0, 0}},
            '{KIND_NOP,  32'hFFFF_FFFF, 1'b1, '{0, 0, 0, 1, 0, 0, 0, 0, 0, 0, 0, 0}},
            '{KIND_PUSH, 32'h7FFF_FFFF, 1'b1,
              '{0, 0, 0, 0, 1, 0, 0, 0, 0, 0, 32'h7FFF_FFFF, 0}},
            '{KIND_PUSH, 32'h8000_0000, 1'b1,
              '{0, 0, 0, 0, 2, 0, 0, 0, 0, 0, 32'h8000_0000, 0}},
            '{KIND_SCAN, 32'h8000_0000, 1'b1,
              '{0, 0, 0, 0, 2, 1, 32'h8000_0000, 32'h7FFF_FFFF, 1, 1, 32'h8000_0000, 0}},
            '{KIND_SCAN, 32'h7FFF_FFFF, 1'b1,
              '{0, 0, 0, 0, 2, 1, 32'h8000_0000, 32'h7FFF_FFFF, 1, 1, 32'h8000_0000, 0}},
            '{KIND_PUSH, 32'hFFFF_FFFF, 1'b0, '0},
            '{KIND_PUSH, 32'h0000_0000, 1'b0, '0},
            '{KIND_PUSH, 32'hFFFF_FFFF, 1'b0, '0},
            '{KIND_SCAN, 32'hFFFF_FFFF, 1'b0, '0},
            '{KIND_SCAN, 32'h1234_5678, 1'b0, '0},
            '{KIND_NOP,  32'h1234_5678, 1'b0, '0},
            '{KIND_POP,  32'h0000_0000, 1'b0, '0},
            '{KIND_POP,  32'hAAAA_AAAA, 1'b0, '0},
            '{KIND_POP,  32'h5555_5555, 1'b0, '0},
            '{KIND_POP,  32'h0000_0000, 1'b0, '0},
            '{KIND_POP,  32'h0000_0000, 1'b1,
              '{0, 0, 0, 1, 0, 0, 0, 0, 0, 0, 0, 32'h7FFF_FFFF}},
            '{KIND_POP,  32'h0000_0000, 1'b1, '{0, 0, 0, 1, 0, 0, 0, 0, 0, 0, 0, 0}},
            '{KIND_PUSH, 32'h0000_0001, 1'b0, '0},
            '{KIND_SCAN, 32'h0000_0001, 1'b0, '0},
            '{KIND_POP,  32'h0000_0000, 1'b0, '0}
        };

        repeat (9) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        for (int i = 0; i < DIR_N; i++)
            send_word(dir_table[i].op, dir_table[i].val, dir_table[i].typed, dir_table[i].exp);

        // Random traffic in segments: the first few fill to overflow, empty the stack, stack
        // up one repeated value and mix everything; later segments are drawn at random.
        done_items = 0;
        seg_idx    = 0;
        while (done_items < RANDOM_ITEMS)
        begin
            case (seg_idx)
                0: mode = SEG_FILL;
                1: mode = SEG_DRAIN;
                2: mode = SEG_REPEAT;
                3: mode = SEG_MIXED;
                default: mode = seg_t'($urandom_range(3));
            endcase
            seg_len = $urandom_range(40, 90);
            if (mode == SEG_FILL)
                seg_len = 90;
            seg_val = pick_value();
            calm    = (seg_idx == 4);
            // The result side stalls for a long stretch while words keep being offered.
            if (seg_idx == 2)
                hold_requests++;
            for (int n = 0; n < seg_len; n++)
            begin
                pick = $urandom_range(99);
                case (mode)
                    SEG_FILL:
                        op = (pick < 85) ? KIND_PUSH : (pick < 97) ? KIND_SCAN : KIND_NOP;
                    SEG_DRAIN:
                        op = (pick < 85) ? KIND_POP : (pick < 95) ? KIND_SCAN : KIND_PUSH;
                    SEG_REPEAT:
                        op = (pick < 70) ? KIND_PUSH : (pick < 90) ? KIND_SCAN : KIND_POP;
                    default:
                        op = (pick < 40) ? KIND_PUSH : (pick < 72) ? KIND_POP :
                             (pick < 94) ? KIND_SCAN : KIND_NOP;
                endcase
                val = (mode == SEG_REPEAT && pick < 90) ? seg_val : pick_value();
                send_word(op, val, 1'b0, '0);
            end
            done_items += seg_len;
            seg_idx++;
            // Now and then the sender waits until every outstanding result has come back.
            if (seg_idx == 1 || $urandom_range(2) == 0)
            begin
                s_tvalid <= 1'b0;
                do
                    @(posedge clk);
                while (pending_results.size() != 0);
            end
        end
        calm = 1'b0;

        s_tvalid <= 1'b0;
        do
            @(posedge clk);
        while (pending_results.size() != 0);
        repeat (DRAIN_CYCLES) @(posedge clk);

        if (mismatches == 0 && pending_results.size() == 0)
            $display("DONE: 0 errors");
        else
            $display("DONE: errors detected");
        $finish;
    end

endmodule
